@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/tfn_pkg.sv @@
`default_nettype none

package tfn_pkg;

    localparam int VERTEX_DEPTH = 4096;
    localparam int ADDR_W       = $clog2(VERTEX_DEPTH);
    localparam int INDEX_W      = 12;
    localparam int COORD_W      = 24;
    localparam int NORMAL_W     = 16;

    localparam int S_TDATA_W    = 112;
    localparam int M_TDATA_W    = 48;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        CMD_WRITE    = 1'b0,
        CMD_TRIANGLE = 1'b1
    } cmd_t;

    // [0] = x, [1] = y, [2] = z
    typedef logic [2:0][COORD_W-1:0] vertex_t;

    typedef struct packed {
        vertex_t c;
        vertex_t b;
        vertex_t a;
    } tri_t;

endpackage

`default_nettype wire

@@ sv/tfn_front.sv @@
`default_nettype none

module tfn_front
    import tfn_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    input  wire logic [QCNT_W-1:0]    q_count,
    output logic                      push,
    output tri_t                      push_data
);

    cmd_t               cmd;
    logic               accept;
    logic [INDEX_W-1:0] idx_a, idx_b, idx_c;
    logic [ADDR_W-1:0]  addr_a, addr_b, addr_c;
    logic               ok_a, ok_b, ok_c;
    logic               wr_en, rd_en;
    vertex_t            wr_vertex;

    vertex_t mem_a [0:VERTEX_DEPTH-1];
    vertex_t mem_b [0:VERTEX_DEPTH-1];
    vertex_t mem_c [0:VERTEX_DEPTH-1];

    vertex_t rd_a_reg, rd_b_reg, rd_c_reg;
    logic    ok_a_reg, ok_b_reg, ok_c_reg;
    logic    rd_valid_reg;

    assign cmd    = cmd_t'(s_tuser);
    assign idx_a  = s_tdata[11:0];
    assign idx_b  = s_tdata[23:12];
    assign idx_c  = s_tdata[35:24];
    assign wr_vertex = {s_tdata[107:84], s_tdata[83:60], s_tdata[59:36]};

    assign addr_a = ADDR_W'(idx_a);
    assign addr_b = ADDR_W'(idx_b);
    assign addr_c = ADDR_W'(idx_c);
    assign ok_a   = int'(idx_a) < VERTEX_DEPTH;
    assign ok_b   = int'(idx_b) < VERTEX_DEPTH;
    assign ok_c   = int'(idx_c) < VERTEX_DEPTH;

    // keep a queue slot for the read in flight
    assign s_tready = (int'(q_count) + int'(rd_valid_reg)) < QUEUE_DEPTH;
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = accept && (cmd == CMD_WRITE) && ok_a;
    assign rd_en    = accept && (cmd == CMD_TRIANGLE);

    // three copies of the store, one read port each
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_a[addr_a] <= wr_vertex;
        end
        if (rd_en) begin
            rd_a_reg <= mem_a[addr_a];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_b[addr_a] <= wr_vertex;
        end
        if (rd_en) begin
            rd_b_reg <= mem_b[addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_c[addr_a] <= wr_vertex;
        end
        if (rd_en) begin
            rd_c_reg <= mem_c[addr_c];
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            ok_a_reg <= ok_a;
            ok_b_reg <= ok_b;
            ok_c_reg <= ok_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= rd_en;
        end
    end

    assign push        = rd_valid_reg;
    assign push_data.a = ok_a_reg ? rd_a_reg : '0;
    assign push_data.b = ok_b_reg ? rd_b_reg : '0;
    assign push_data.c = ok_c_reg ? rd_c_reg : '0;

endmodule

`default_nettype wire

@@ sv/tfn_queue.sv @@
`default_nettype none

module tfn_queue
    import tfn_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire tri_t              push_data,
    input  wire logic              pop,
    output logic                   q_valid,
    output tri_t                   q_data,
    output logic [QCNT_W-1:0]      q_count
);

    tri_t              buf_reg [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign q_valid = count_reg != '0;
    assign q_data  = buf_reg[rd_ptr_reg];
    assign q_count = count_reg;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/tfn_back.sv @@
`default_nettype none

module tfn_back
    import tfn_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 q_valid,
    input  wire tri_t                 q_data,
    output logic                      pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tuser
);

    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int NORM_W     = 64;
    localparam int NORM_STEPS = 6;
    localparam int MAG_W      = 30;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int FRAC_W     = 14;
    localparam int DIV_W      = MAG_W + FRAC_W + 2;
    localparam int Q_W        = FRAC_W + 1;
    localparam int NSTAGE     = 4 + NORM_STEPS + 2 + ROOT_W + 1 + Q_W;
    localparam logic [Q_W-1:0] Q_ONE = Q_W'(1 << FRAC_W);

    typedef struct packed {
        logic [2:0] neg;
        logic       deg;
    } side_t;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  deg;
    } carry_t;

    logic adv;
    logic [NSTAGE-1:0] valid_reg;

    logic signed [DIFF_W-1:0]  u_reg [3];
    logic signed [DIFF_W-1:0]  v_reg [3];
    logic signed [PROD_W-1:0]  p_reg [6];
    logic signed [CROSS_W-1:0] n_reg [3];
    logic [CROSS_W-1:0]        mag_reg [3];
    side_t                     mside_reg;

    logic [NORM_W-1:0] nw_reg   [NORM_STEPS][3];
    logic [NORM_W-1:0] nw_next  [NORM_STEPS][3];
    side_t             ns_reg   [NORM_STEPS];
    side_t             ns_next  [NORM_STEPS];

    logic [SQ_W-1:0]   sq_reg [3];
    carry_t            sq_c_reg;
    logic [SUM_W-1:0]  sum_reg;
    carry_t            sum_c_reg;

    logic [REM_W-1:0]  rt_rem_reg   [ROOT_W];
    logic [REM_W-1:0]  rt_rem_next  [ROOT_W];
    logic [ROOT_W-1:0] rt_root_reg  [ROOT_W];
    logic [ROOT_W-1:0] rt_root_next [ROOT_W];
    logic [SUM_W-1:0]  rt_s_reg     [ROOT_W];
    logic [SUM_W-1:0]  rt_s_next    [ROOT_W];
    carry_t            rt_c_reg     [ROOT_W];
    carry_t            rt_c_next    [ROOT_W];

    logic [DIV_W-1:0]  di_num_reg [3];
    logic [ROOT_W-1:0] di_len_reg;
    carry_t            di_c_reg;

    logic [DIV_W-1:0]  dv_rem_reg  [Q_W][3];
    logic [DIV_W-1:0]  dv_rem_next [Q_W][3];
    logic [Q_W-1:0]    dv_q_reg    [Q_W][3];
    logic [Q_W-1:0]    dv_q_next   [Q_W][3];
    logic [ROOT_W-1:0] dv_len_reg  [Q_W];
    logic [ROOT_W-1:0] dv_len_next [Q_W];
    carry_t            dv_c_reg    [Q_W];
    carry_t            dv_c_next   [Q_W];

    logic [M_TDATA_W-1:0] out_data;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;
    logic                 m_tvalid_reg;

    assign adv = !m_tvalid_reg || m_tready;
    assign pop = adv && q_valid;

    // leading-zero normaliser: bring the largest magnitude to the top bit
    always_comb begin
        for (int s = 0; s < NORM_STEPS; s++) begin : l_norm
            logic [NORM_W-1:0] src [3];
            logic [NORM_W-1:0] orv;
            side_t             sd;
            logic              hit;
            if (s == 0) begin
                for (int i = 0; i < 3; i++) begin
                    src[i] = NORM_W'(mag_reg[i]);
                end
                sd = mside_reg;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    src[i] = nw_reg[s-1][i];
                end
                sd = ns_reg[s-1];
            end
            orv = src[0] | src[1] | src[2];
            hit = (orv >> (NORM_W - (1 << (NORM_STEPS - 1 - s)))) == '0;
            for (int i = 0; i < 3; i++) begin
                nw_next[s][i] = hit ? (src[i] << (1 << (NORM_STEPS - 1 - s))) : src[i];
            end
            ns_next[s] = sd;
        end
    end

    // square root, two radicand bits a stage
    always_comb begin
        for (int k = 0; k < ROOT_W; k++) begin : l_root
            logic [REM_W-1:0]  rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [SUM_W-1:0]  s_in;
            carry_t            c_in;
            logic [REM_W+1:0]  pre;
            logic [REM_W+1:0]  trial;
            logic              ge;
            if (k == 0) begin
                rem_in  = '0;
                root_in = '0;
                s_in    = sum_reg;
                c_in    = sum_c_reg;
            end else begin
                rem_in  = rt_rem_reg[k-1];
                root_in = rt_root_reg[k-1];
                s_in    = rt_s_reg[k-1];
                c_in    = rt_c_reg[k-1];
            end
            pre   = {rem_in, s_in[SUM_W-1 -: 2]};
            trial = (REM_W + 2)'({root_in, 2'b01});
            ge    = pre >= trial;
            rt_rem_next[k]  = ge ? REM_W'(pre - trial) : REM_W'(pre);
            rt_root_next[k] = {root_in[ROOT_W-2:0], ge};
            rt_s_next[k]    = s_in << 2;
            rt_c_next[k]    = c_in;
        end
    end

    // restoring divide, one quotient bit a stage on each lane
    always_comb begin
        for (int k = 0; k < Q_W; k++) begin : l_div
            logic [DIV_W-1:0]  rem_in [3];
            logic [Q_W-1:0]    q_in   [3];
            logic [ROOT_W-1:0] len_in;
            carry_t            c_in;
            logic [DIV_W-1:0]  dsr;
            logic              ge;
            if (k == 0) begin
                for (int i = 0; i < 3; i++) begin
                    rem_in[i] = di_num_reg[i];
                    q_in[i]   = '0;
                end
                len_in = di_len_reg;
                c_in   = di_c_reg;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    rem_in[i] = dv_rem_reg[k-1][i];
                    q_in[i]   = dv_q_reg[k-1][i];
                end
                len_in = dv_len_reg[k-1];
                c_in   = dv_c_reg[k-1];
            end
            dsr = DIV_W'(len_in) << (Q_W - 1 - k);
            for (int i = 0; i < 3; i++) begin
                ge = rem_in[i] >= dsr;
                dv_rem_next[k][i] = ge ? rem_in[i] - dsr : rem_in[i];
                dv_q_next[k][i]   = {q_in[i][Q_W-2:0], ge};
            end
            dv_len_next[k] = len_in;
            dv_c_next[k]   = c_in;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin : l_out
            logic [Q_W-1:0] q;
            q = (dv_q_reg[Q_W-1][i] > Q_ONE) ? Q_ONE : dv_q_reg[Q_W-1][i];
            if (dv_c_reg[Q_W-1].deg) begin
                out_data[i*NORMAL_W +: NORMAL_W] = '0;
            end else if (dv_c_reg[Q_W-1].neg[i]) begin
                out_data[i*NORMAL_W +: NORMAL_W] = NORMAL_W'(0) - NORMAL_W'(q);
            end else begin
                out_data[i*NORMAL_W +: NORMAL_W] = NORMAL_W'(q);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                u_reg[i] <= $signed({q_data.b[i][COORD_W-1], q_data.b[i]})
                          - $signed({q_data.a[i][COORD_W-1], q_data.a[i]});
                v_reg[i] <= $signed({q_data.c[i][COORD_W-1], q_data.c[i]})
                          - $signed({q_data.a[i][COORD_W-1], q_data.a[i]});
            end

            p_reg[0] <= u_reg[1] * v_reg[2];
            p_reg[1] <= u_reg[2] * v_reg[1];
            p_reg[2] <= u_reg[2] * v_reg[0];
            p_reg[3] <= u_reg[0] * v_reg[2];
            p_reg[4] <= u_reg[0] * v_reg[1];
            p_reg[5] <= u_reg[1] * v_reg[0];

            // negated cross product
            n_reg[0] <= CROSS_W'(p_reg[1]) - CROSS_W'(p_reg[0]);
            n_reg[1] <= CROSS_W'(p_reg[3]) - CROSS_W'(p_reg[2]);
            n_reg[2] <= CROSS_W'(p_reg[5]) - CROSS_W'(p_reg[4]);

            for (int i = 0; i < 3; i++) begin
                mag_reg[i]       <= n_reg[i][CROSS_W-1] ? CROSS_W'(-n_reg[i]) : CROSS_W'(n_reg[i]);
                mside_reg.neg[i] <= n_reg[i][CROSS_W-1];
            end
            mside_reg.deg <= (n_reg[0] == '0) && (n_reg[1] == '0) && (n_reg[2] == '0);

            nw_reg <= nw_next;
            ns_reg <= ns_next;

            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= SQ_W'(nw_reg[NORM_STEPS-1][i][NORM_W-1 -: MAG_W])
                           * SQ_W'(nw_reg[NORM_STEPS-1][i][NORM_W-1 -: MAG_W]);
                sq_c_reg.mag[i] <= nw_reg[NORM_STEPS-1][i][NORM_W-1 -: MAG_W];
            end
            sq_c_reg.neg <= ns_reg[NORM_STEPS-1].neg;
            sq_c_reg.deg <= ns_reg[NORM_STEPS-1].deg;

            sum_reg   <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            sum_c_reg <= sq_c_reg;

            rt_rem_reg  <= rt_rem_next;
            rt_root_reg <= rt_root_next;
            rt_s_reg    <= rt_s_next;
            rt_c_reg    <= rt_c_next;

            for (int i = 0; i < 3; i++) begin
                di_num_reg[i] <= DIV_W'({rt_c_reg[ROOT_W-1].mag[i], FRAC_W'(0)})
                               + DIV_W'(rt_root_reg[ROOT_W-1] >> 1);
            end
            di_len_reg <= rt_root_reg[ROOT_W-1];
            di_c_reg   <= rt_c_reg[ROOT_W-1];

            dv_rem_reg <= dv_rem_next;
            dv_q_reg   <= dv_q_next;
            dv_len_reg <= dv_len_next;
            dv_c_reg   <= dv_c_next;

            m_tdata_reg <= out_data;
            m_tuser_reg <= dv_c_reg[Q_W-1].deg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg    <= {valid_reg[NSTAGE-2:0], q_valid};
            m_tvalid_reg <= valid_reg[NSTAGE-1];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

@@ sv/triangle_face_normal.sv @@
// Triangle face normal unit.
// Input channel s_*: tuser = 0 writes vertex (pos_x, pos_y, pos_z) at
// index_a into the vertex store and gives no result; tuser = 1 reads the
// corners at index_a, index_b and index_c and gives one result.
// Result channel m_*: normal_x/y/z in signed Q1.14, tuser marks a degenerate
// triangle, in which case the normal is the zero vector.
// Throughput: one transaction per cycle on each side while neither side
// stalls; the cross product, normaliser, 31-stage square root and 15-stage
// divider are fully pipelined. A result passes the registered store read,
// the four-entry queue and then that pipeline before it reaches m_tvalid.
// A vertex written in one cycle can be read by a triangle in the next.
// Reset clears the pipeline and queue control; the store is not cleared,
// and a vertex must be written before any triangle reads it.
// With m_tvalid high and m_tready low the back pipeline holds; the front
// takes writes and triangles until queue slots run out, then drops s_tready.
`default_nettype none

module triangle_face_normal
    import tfn_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // index_a, index_b, index_c, pos_x, pos_y, pos_z, zero fill
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // cmd
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // normal_x, normal_y, normal_z
    output logic [M_TDATA_W-1:0]      m_tdata,
    // degenerate
    output logic                      m_tuser
);

    logic              push;
    tri_t              push_data;
    logic              pop;
    logic              q_valid;
    tri_t              q_data;
    logic [QCNT_W-1:0] q_count;

    tfn_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_count   (q_count),
        .push      (push),
        .push_data (push_data)
    );

    tfn_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_count   (q_count)
    );

    tfn_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

@@ sv/tfn_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module tfn_checker
    import tfn_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tuser
);

    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    `ASSERT_CLK(a_deg_zero, aclk, aresetn, m_tvalid && m_tuser |-> m_tdata == '0, "degenerate result carries a non-zero normal")

    `ASSERT_CLK(a_normal_nonzero, aclk, aresetn, m_tvalid && !m_tuser |-> m_tdata != '0, "unit normal came out as zero")

    `ASSERT_CLK(a_range, aclk, aresetn, m_tvalid |-> $signed(m_tdata[15:0]) <= 16384 && $signed(m_tdata[15:0]) >= -16384 && $signed(m_tdata[31:16]) <= 16384 && $signed(m_tdata[31:16]) >= -16384 && $signed(m_tdata[47:32]) <= 16384 && $signed(m_tdata[47:32]) >= -16384, "normal component out of Q1.14 range")

    `ASSERT_CLK_NR(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "result valid straight after reset")

endmodule

bind triangle_face_normal tfn_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

@@ verif/tb.sv @@
`default_nettype none

module tb;
    import tfn_pkg::*;

    typedef struct {
        cmd_t             cmd;
        logic [11:0]      ia, ib, ic;
        logic [23:0]      px, py, pz;
        int               phase;
    } vertex_cmd_t;

    typedef struct {
        logic [2:0][15:0] nrm;
        logic             degen;
    } face_normal_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tuser;

    vertex_cmd_t  pending_q[$];
    face_normal_t normals_due[$];
    vertex_cmd_t  on_bus;
    vertex_t      mesh_store [0:VERTEX_DEPTH-1];
    bit           gen_written [0:VERTEX_DEPTH-1];
    int           gen_written_q[$];
    int           gen_phase = 0;
    int           bus_phase = 0;
    int           fails = 0;
    int           quiet_cycles = 0;

    triangle_face_normal i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] step;
        res = 0;
        step = 64'd1 << 62;
        while (step > v) step >>= 2;
        while (step != 0) begin
            if (v >= res + step) begin
                v -= res + step;
                res = (res >> 1) + step;
            end else begin
                res >>= 1;
            end
            step >>= 2;
        end
        return res;
    endfunction

    function automatic face_normal_t face_normal(vertex_t a, vertex_t b, vertex_t c);
        longint       u[3], v[3], n[3];
        logic [63:0]  mag[3];
        logic [63:0]  mx, sum, len, q;
        face_normal_t r;
        for (int i = 0; i < 3; i++) begin
            u[i] = longint'(signed'(b[i])) - longint'(signed'(a[i]));
            v[i] = longint'(signed'(c[i])) - longint'(signed'(a[i]));
        end
        n[0] = -(u[1] * v[2] - u[2] * v[1]);
        n[1] = -(u[2] * v[0] - u[0] * v[2]);
        n[2] = -(u[0] * v[1] - u[1] * v[0]);
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (n[i] < 0) ? -n[i] : n[i];
            if (mag[i] > mx) mx = mag[i];
        end
        r.nrm = '0;
        r.degen = (mx == 0);
        if (mx == 0) return r;
        while (mx < (64'd1 << 29)) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        while (mx >= (64'd1 << 30)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] * 16384 + (len >> 1)) / len;
            if (q > 16384) q = 16384;
            r.nrm[i] = (n[i] < 0) ? -q[15:0] : q[15:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t",
                 field, $signed(got), $signed(want), $realtime);
        fails++;
    endtask

    task automatic add_write(int idx, logic [23:0] x, logic [23:0] y, logic [23:0] z);
        vertex_cmd_t it;
        it.cmd = CMD_WRITE;
        it.ia = 12'(idx);
        it.ib = 12'($urandom);
        it.ic = 12'($urandom);
        it.px = x;
        it.py = y;
        it.pz = z;
        it.phase = gen_phase;
        pending_q.push_back(it);
        if (!gen_written[idx]) begin
            gen_written[idx] = 1'b1;
            gen_written_q.push_back(idx);
        end
    endtask

    task automatic add_triangle(int a, int b, int c);
        vertex_cmd_t it;
        it.cmd = CMD_TRIANGLE;
        it.ia = 12'(a);
        it.ib = 12'(b);
        it.ic = 12'(c);
        it.px = 24'($urandom);
        it.py = 24'($urandom);
        it.pz = 24'($urandom);
        it.phase = gen_phase;
        pending_q.push_back(it);
    endtask

    function automatic logic [23:0] rand_coord();
        logic [23:0] x;
        x = 24'($urandom);
        if ($urandom_range(2) == 0) x = $signed(x) >>> $urandom_range(20);
        return x;
    endfunction

    function automatic int pick_written();
        return gen_written_q[$urandom_range(gen_written_q.size() - 1)];
    endfunction

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (on_bus.cmd == CMD_WRITE) begin
                    mesh_store[on_bus.ia] <= {on_bus.pz, on_bus.py, on_bus.px};
                end else begin
                    normals_due.push_back(face_normal(mesh_store[on_bus.ia],
                                                      mesh_store[on_bus.ib],
                                                      mesh_store[on_bus.ic]));
                end
            end
            if (!s_tvalid || s_tready) begin
                if (pending_q.size() != 0 &&
                    !((pending_q[0].phase == 1 && $urandom_range(99) < 86) ||
                      (pending_q[0].phase == 3 && $urandom_range(99) < 38))) begin
                    on_bus = pending_q.pop_front();
                    bus_phase <= on_bus.phase;
                    s_tvalid <= 1'b1;
                    s_tuser <= on_bus.cmd;
                    s_tdata <= {4'b0, on_bus.pz, on_bus.py, on_bus.px,
                                on_bus.ic, on_bus.ib, on_bus.ia};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        face_normal_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (normals_due.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata[15:0], 16'd0);
                end else begin
                    want = normals_due.pop_front();
                    if (m_tdata[15:0] !== want.nrm[0])
                        report_mismatch("normal_x", m_tdata[15:0], want.nrm[0]);
                    if (m_tdata[31:16] !== want.nrm[1])
                        report_mismatch("normal_y", m_tdata[31:16], want.nrm[1]);
                    if (m_tdata[47:32] !== want.nrm[2])
                        report_mismatch("normal_z", m_tdata[47:32], want.nrm[2]);
                    if (m_tuser !== want.degen)
                        report_mismatch("degenerate", 16'(m_tuser), 16'(want.degen));
                end
            end
            if (bus_phase == 2)
                m_tready <= $urandom_range(99) >= 86;
            else if (bus_phase == 3)
                m_tready <= $urandom_range(99) >= 38;
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (pending_q.size() == 0 && !s_tvalid && normals_due.size() == 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= 5000) begin
            $display("triangle_face_normal verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int a, b, c;
        // extremes, axes, degenerate and collinear triangles
        add_write(0, 24'h000000, 24'h000000, 24'h000000);
        add_write(4095, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        add_write(1, 24'h800000, 24'h800000, 24'h800000);
        add_write(2, 24'h7FFFFF, 24'h800000, 24'h000000);
        add_write(3, 24'h000100, 24'h000000, 24'h000000);
        add_write(4, 24'h000000, 24'h000100, 24'h000000);
        add_write(5, 24'h000000, 24'h000000, 24'h000100);
        add_write(6, 24'h800000, 24'h7FFFFF, 24'h800000);
        add_triangle(0, 3, 4);
        add_triangle(0, 4, 3);
        add_triangle(0, 3, 5);
        add_triangle(0, 4, 5);
        add_triangle(1, 4095, 2);
        add_triangle(1, 6, 4095);
        add_triangle(4095, 1, 2);
        add_triangle(0, 0, 0);
        add_triangle(0, 1, 4095);
        add_triangle(3, 3, 4);
        add_write(2730, 24'h555555, 24'hAAAAAA, 24'h000001);
        add_write(1365, 24'hAAAAAA, 24'h555555, 24'hFFFFFF);
        add_triangle(2730, 1365, 4095);
        add_triangle(1365, 2730, 1);
        for (int ph = 0; ph < 4; ph++) begin
            gen_phase = ph;
            for (int k = 0; k < 120; k++) begin
                if ($urandom_range(99) < 45) begin
                    a = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(31);
                    add_write(a, rand_coord(), rand_coord(), rand_coord());
                end else begin
                    a = pick_written();
                    b = pick_written();
                    c = pick_written();
                    if ($urandom_range(99) < 15) begin
                        if ($urandom_range(1)) b = a;
                        else c = b;
                    end
                    add_triangle(a, b, c);
                end
            end
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_q.size() != 0 || s_tvalid || normals_due.size() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fails == 0)
            $display("triangle_face_normal verification clean");
        else
            $display("triangle_face_normal verification failed");
        $finish;
    end

endmodule

`default_nettype wire
